### hdl/glyph_quad_text_layout_core_defines.svh
// Assertion macros shared by the layout core.
`ifndef GLYPH_QUAD_TEXT_LAYOUT_CORE_DEFINES_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GQTL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GQTL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/gqtl_pkg.sv
package gqtl_pkg;

    // Input command codes.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_CHAR  = 2'd2;

    // Character codes with a pen action of their own.
    localparam logic [7:0] CODE_TAB     = 8'd9;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_SPACE   = 8'd32;

    // Configuration register indexes.
    localparam logic [2:0] REG_SCALE       = 3'd0;
    localparam logic [2:0] REG_SPACE_WIDTH = 3'd1;
    localparam logic [2:0] REG_TAB_WIDTH   = 3'd2;
    localparam logic [2:0] REG_LINE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_BASELINE    = 3'd4;
    localparam logic [2:0] REG_ROOT_X      = 3'd5;
    localparam logic [2:0] REG_ROOT_Y      = 3'd6;

    localparam int APB_ADDR_W = 5;
    localparam int S_TDATA_W  = 160;
    localparam int M_TDATA_W  = 208;

    // Scaled widths: signed metric gives 29 bits, signed sum of two metrics
    // gives 30 bits, unsigned size gives 27 bits.
    localparam int STEP_W = 29;
    localparam int OFFY_W = 30;
    localparam int SIZE_W = 27;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_START,
        OP_SPACE,
        OP_TAB,
        OP_NEWLINE,
        OP_GLYPH
    } op_t;

    typedef struct packed {
        logic        [15:0] scale;
        logic signed [15:0] space_width;
        logic signed [15:0] tab_width;
        logic signed [15:0] line_height;
        logic signed [15:0] baseline;
        logic signed [31:0] root_x;
        logic signed [31:0] root_y;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic        [14:0] glyph_width;
        logic        [14:0] glyph_height;
        logic signed [15:0] advance;
        logic        [7:0]  page_id;
        logic        [15:0] tex_left;
        logic        [15:0] tex_top;
        logic        [15:0] tex_right;
        logic        [15:0] tex_bottom;
    } glyph_entry_t;

    typedef struct packed {
        logic         present;
        glyph_entry_t entry;
    } glyph_word_t;

    // Item waiting for the table read data.
    typedef struct packed {
        op_t        op;
        logic [7:0] code;
    } s1_t;

    // Item with all scaled terms, ready for the pen update.
    typedef struct packed {
        op_t                      op;
        logic [7:0]               code;
        logic signed [STEP_W-1:0] step;
        logic signed [STEP_W-1:0] off_x;
        logic signed [OFFY_W-1:0] off_y;
        logic [SIZE_W-1:0]        size_w;
        logic [SIZE_W-1:0]        size_h;
        logic [15:0]              tex_left;
        logic [15:0]              tex_top;
        logic [15:0]              tex_right;
        logic [15:0]              tex_bottom;
        logic [7:0]               page_id;
    } s2_t;

    typedef struct packed {
        logic signed [31:0] quad_x;
        logic signed [31:0] quad_y;
        logic [30:0]        quad_width;
        logic [30:0]        quad_height;
        logic [15:0]        uv_left;
        logic [15:0]        uv_top;
        logic [15:0]        uv_right;
        logic [15:0]        uv_bottom;
        logic [7:0]         quad_page;
        logic [7:0]         quad_char;
    } quad_t;

    // Clamp a sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = {1'b1, 31'd0};
        end else begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

endpackage

### hdl/glyph_quad_text_layout_core.sv
// Channel   | Direction | Transaction contents
// ----------+-----------+-----------------------------------------------
// s_        | in        | command in tuser, glyph load or character in tdata
// m_        | out       | one glyph quad per emitted character
// APB       | in/out    | scale, widths, baseline and root position
//
// One item is accepted per cycle while s_tready is high; a quad reaches m_ from its
// accepted character through the table read into stage one, the scaling multipliers
// into stage two and the pen update into the output register.
// After reset a clearing pass over all GLYPH_COUNT entries marks every glyph absent;
// s_tready stays low during it while configuration writes are still taken.
// A quad held in the output register stalls the next glyph in stage two and
// everything behind it; spaces, tabs, newlines and starts ahead of it flow on.
module glyph_quad_text_layout_core #(
    parameter int GLYPH_COUNT = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: char_code, offset_x, offset_y, glyph_width, glyph_height, advance,
    //        tex_left, tex_top, tex_right, tex_bottom, page_id, zero fill
    input  logic [gqtl_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: cmd
    input  logic [1:0]                        s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: quad_x, quad_y, quad_width, quad_height, uv_left, uv_top,
    //        uv_right, uv_bottom, quad_page, quad_char, zero fill
    output logic [gqtl_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gqtl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

`include "glyph_quad_text_layout_core_defines.svh"

    localparam int IDX_W = $clog2(GLYPH_COUNT);

    gqtl_pkg::cfg_t        cfg_reg, cfg_next;
    logic                  cfg_wr;
    logic [2:0]            reg_idx;

    logic [7:0]            in_code;
    logic [1:0]            in_cmd;
    gqtl_pkg::glyph_entry_t in_entry;
    logic [IDX_W+7:0]      code_wide;
    logic [IDX_W-1:0]      tbl_addr;
    logic                  in_range;
    logic                  accept;
    gqtl_pkg::op_t         in_op;

    logic                  tbl_busy;
    gqtl_pkg::glyph_word_t tbl_rd_data;
    logic                  tbl_wr_en;

    logic                  s1_valid_reg, s1_valid_next;
    gqtl_pkg::s1_t         s1_reg, s1_next;
    logic                  s1_adv;
    logic                  s0_push;

    logic                  s2_valid;
    gqtl_pkg::s2_t         s2;
    logic                  s2_take;
    gqtl_pkg::quad_t       quad;

    // Configuration registers.
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                gqtl_pkg::REG_SCALE:       cfg_next.scale       = pwdata[15:0];
                gqtl_pkg::REG_SPACE_WIDTH: cfg_next.space_width = pwdata[15:0];
                gqtl_pkg::REG_TAB_WIDTH:   cfg_next.tab_width   = pwdata[15:0];
                gqtl_pkg::REG_LINE_HEIGHT: cfg_next.line_height = pwdata[15:0];
                gqtl_pkg::REG_BASELINE:    cfg_next.baseline    = pwdata[15:0];
                gqtl_pkg::REG_ROOT_X:      cfg_next.root_x      = pwdata;
                gqtl_pkg::REG_ROOT_Y:      cfg_next.root_y      = pwdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{scale: 16'd256, default: '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            gqtl_pkg::REG_SCALE:       prdata = {16'd0, cfg_reg.scale};
            gqtl_pkg::REG_SPACE_WIDTH: prdata = {16'd0, cfg_reg.space_width};
            gqtl_pkg::REG_TAB_WIDTH:   prdata = {16'd0, cfg_reg.tab_width};
            gqtl_pkg::REG_LINE_HEIGHT: prdata = {16'd0, cfg_reg.line_height};
            gqtl_pkg::REG_BASELINE:    prdata = {16'd0, cfg_reg.baseline};
            gqtl_pkg::REG_ROOT_X:      prdata = cfg_reg.root_x;
            gqtl_pkg::REG_ROOT_Y:      prdata = cfg_reg.root_y;
            default:                   prdata = '0;
        endcase
    end

    // Unpack the input transaction.
    assign in_cmd                = s_tuser;
    assign in_code               = s_tdata[7:0];
    assign in_entry.offset_x     = s_tdata[23:8];
    assign in_entry.offset_y     = s_tdata[39:24];
    assign in_entry.glyph_width  = s_tdata[54:40];
    assign in_entry.glyph_height = s_tdata[69:55];
    assign in_entry.advance      = s_tdata[85:70];
    assign in_entry.tex_left     = s_tdata[101:86];
    assign in_entry.tex_top      = s_tdata[117:102];
    assign in_entry.tex_right    = s_tdata[133:118];
    assign in_entry.tex_bottom   = s_tdata[149:134];
    assign in_entry.page_id      = s_tdata[157:150];

    assign code_wide = {{IDX_W{1'b0}}, in_code};
    assign tbl_addr  = code_wide[IDX_W-1:0];
    assign in_range  = 32'(in_code) < 32'(GLYPH_COUNT);

    // Decode the command into a pipeline operation.
    always_comb begin
        in_op = gqtl_pkg::OP_NOP;
        case (in_cmd)
            gqtl_pkg::CMD_START: in_op = gqtl_pkg::OP_START;
            gqtl_pkg::CMD_CHAR: begin
                if (in_code == gqtl_pkg::CODE_SPACE) begin
                    in_op = gqtl_pkg::OP_SPACE;
                end else if (in_code == gqtl_pkg::CODE_NEWLINE) begin
                    in_op = gqtl_pkg::OP_NEWLINE;
                end else if (in_code == gqtl_pkg::CODE_TAB) begin
                    in_op = gqtl_pkg::OP_TAB;
                end else if (in_range) begin
                    in_op = gqtl_pkg::OP_GLYPH;
                end
            end
            default: in_op = gqtl_pkg::OP_NOP;
        endcase
    end

    // Input handshake: the table must not be clearing and stage one must be free or moving on.
    assign s_tready  = !tbl_busy && (!s1_valid_reg || s1_adv);
    assign accept    = s_tvalid && s_tready;
    assign s0_push   = accept && in_op != gqtl_pkg::OP_NOP;
    assign tbl_wr_en = accept && in_cmd == gqtl_pkg::CMD_LOAD && in_range;

    gqtl_glyph_table #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .IDX_W       (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (tbl_addr),
        .rd_data  (tbl_rd_data),
        .wr_en    (tbl_wr_en),
        .wr_addr  (tbl_addr),
        .wr_entry (in_entry),
        .busy     (tbl_busy)
    );

    // Stage one holds the item while the table read completes.
    assign s1_adv       = s1_valid_reg && (!s2_valid || s2_take);
    assign s1_next.op   = in_op;
    assign s1_next.code = in_code;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s0_push) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv || accept) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s0_push) begin
            s1_reg <= s1_next;
        end
    end

    gqtl_scale_stage u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1_adv   (s1_adv),
        .s1       (s1_reg),
        .rd_data  (tbl_rd_data),
        .cfg      (cfg_reg),
        .s2_take  (s2_take),
        .s2_valid (s2_valid),
        .s2       (s2)
    );

    gqtl_pen_stage u_pen (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s2_valid (s2_valid),
        .s2       (s2),
        .cfg      (cfg_reg),
        .s2_take  (s2_take),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .quad     (quad)
    );

    // Pack the result transaction.
    assign m_tdata = {2'd0, quad.quad_char, quad.quad_page, quad.uv_bottom,
                      quad.uv_right, quad.uv_top, quad.uv_left, quad.quad_height,
                      quad.quad_width, quad.quad_y, quad.quad_x};

    // Nothing is in flight while the table is being cleared.
    `GQTL_ASSERT_NOW(a_clear_blocks_input, aclk, aresetn, tbl_busy, !s_tready,
        "input accepted during clearing pass")
    `GQTL_ASSERT_NOW(a_clear_pipe_empty, aclk, aresetn, tbl_busy,
        !s1_valid_reg && !s2_valid && !m_tvalid, "pipeline busy during clearing pass")
    // Only a glyph waiting on a full output register may hold stage two.
    `GQTL_ASSERT_NOW(a_s2_stall_cause, aclk, aresetn, s2_valid && !s2_take,
        s2.op == gqtl_pkg::OP_GLYPH && m_tvalid && !m_tready,
        "stage two stalled without a blocked glyph")
    // A stalled stage-one item must still be there next cycle.
    `GQTL_ASSERT_NEXT(a_s1_hold, aclk, aresetn, s1_valid_reg && !s1_adv,
        s1_valid_reg, "stage one item lost while stalled")

endmodule

### hdl/gqtl_glyph_table.sv
module gqtl_glyph_table #(
    parameter int GLYPH_COUNT = 256,
    parameter int IDX_W       = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic [IDX_W-1:0]           rd_addr,
    output gqtl_pkg::glyph_word_t      rd_data,
    input  logic                       wr_en,
    input  logic [IDX_W-1:0]           wr_addr,
    input  gqtl_pkg::glyph_entry_t     wr_entry,
    output logic                       busy
);

    gqtl_pkg::glyph_word_t glyph_mem [GLYPH_COUNT];
    gqtl_pkg::glyph_word_t rd_data_reg;

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    gqtl_pkg::glyph_word_t mem_wdata;

    // Clearing pass after reset: one entry per cycle marked absent.
    always_comb begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg) begin
            clr_addr_next = clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == IDX_W'(GLYPH_COUNT - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Write port is shared by the clearing pass and glyph loads.
    always_comb begin
        if (busy_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we            = wr_en;
            mem_waddr         = wr_addr;
            mem_wdata.present = 1'b1;
            mem_wdata.entry   = wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            glyph_mem[mem_waddr] <= mem_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= glyph_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

### hdl/gqtl_scale_stage.sv
module gqtl_scale_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s1_adv,
    input  gqtl_pkg::s1_t         s1,
    input  gqtl_pkg::glyph_word_t rd_data,
    input  gqtl_pkg::cfg_t        cfg,
    input  logic                  s2_take,
    output logic                  s2_valid,
    output gqtl_pkg::s2_t         s2
);

    logic          s2_valid_reg, s2_valid_next;
    gqtl_pkg::s2_t s2_reg, s2_next;
    gqtl_pkg::op_t op_res;

    logic signed [16:0] scale_s;
    logic signed [15:0] step_m;
    logic signed [16:0] base_sum;
    logic signed [32:0] step_p;
    logic signed [32:0] offx_p;
    logic signed [33:0] offy_p;
    logic        [30:0] w_p;
    logic        [30:0] h_p;

    assign scale_s = $signed({1'b0, cfg.scale});

    // A glyph code whose entry was never loaded turns into a no-op.
    always_comb begin
        op_res = s1.op;
        if (s1.op == gqtl_pkg::OP_GLYPH && !rd_data.present) begin
            op_res = gqtl_pkg::OP_NOP;
        end
    end

    // Pick the metric that moves the pen.
    always_comb begin
        case (s1.op)
            gqtl_pkg::OP_SPACE:   step_m = cfg.space_width;
            gqtl_pkg::OP_TAB:     step_m = cfg.tab_width;
            gqtl_pkg::OP_NEWLINE: step_m = cfg.line_height;
            gqtl_pkg::OP_GLYPH:   step_m = rd_data.entry.advance;
            default:              step_m = '0;
        endcase
    end

    // Each scaled term is the product shifted down four bits; the arithmetic
    // shift of the product floors toward minus infinity.
    assign base_sum = 17'(cfg.baseline) + 17'(rd_data.entry.offset_y);
    assign step_p   = 33'(step_m) * 33'(scale_s);
    assign offx_p   = 33'(rd_data.entry.offset_x) * 33'(scale_s);
    assign offy_p   = 34'(base_sum) * 34'(scale_s);
    assign w_p      = 31'(rd_data.entry.glyph_width) * 31'(cfg.scale);
    assign h_p      = 31'(rd_data.entry.glyph_height) * 31'(cfg.scale);

    always_comb begin
        s2_next.op         = op_res;
        s2_next.code       = s1.code;
        s2_next.step       = step_p[32:4];
        s2_next.off_x      = offx_p[32:4];
        s2_next.off_y      = offy_p[33:4];
        s2_next.size_w     = w_p[30:4];
        s2_next.size_h     = h_p[30:4];
        s2_next.tex_left   = rd_data.entry.tex_left;
        s2_next.tex_top    = rd_data.entry.tex_top;
        s2_next.tex_right  = rd_data.entry.tex_right;
        s2_next.tex_bottom = rd_data.entry.tex_bottom;
        s2_next.page_id    = rd_data.entry.page_id;
    end

    // Stage occupancy: no-ops are dropped here.
    always_comb begin
        s2_valid_next = s2_valid_reg;
        if (s1_adv) begin
            s2_valid_next = (op_res != gqtl_pkg::OP_NOP);
        end else if (s2_take) begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

endmodule

### hdl/gqtl_pen_stage.sv
module gqtl_pen_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s2_valid,
    input  gqtl_pkg::s2_t  s2,
    input  gqtl_pkg::cfg_t cfg,
    output logic           s2_take,
    output logic           m_valid,
    input  logic           m_ready,
    output gqtl_pkg::quad_t quad
);

    logic signed [31:0] pen_x_reg, pen_x_next;
    logic signed [31:0] pen_y_reg, pen_y_next;
    logic               m_valid_reg, m_valid_next;
    gqtl_pkg::quad_t    quad_reg, quad_next;

    logic               out_free;
    logic               emit;
    logic signed [33:0] sum_x_step;
    logic signed [33:0] sum_y_line;
    logic signed [33:0] sum_qx;
    logic signed [33:0] sum_qy;
    logic signed [33:0] size_h_s;

    // The output register can take a quad when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign s2_take  = s2_valid && (s2.op != gqtl_pkg::OP_GLYPH || out_free);
    assign emit     = s2_take && s2.op == gqtl_pkg::OP_GLYPH;

    assign size_h_s   = $signed({7'd0, s2.size_h});
    assign sum_x_step = 34'(pen_x_reg) + 34'(s2.step);
    assign sum_y_line = 34'(pen_y_reg) - 34'(s2.step);
    assign sum_qx     = 34'(pen_x_reg) + 34'(s2.off_x);
    assign sum_qy     = 34'(pen_y_reg) - size_h_s + 34'(s2.off_y);

    // Pen update for the item leaving this stage.
    always_comb begin
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        if (s2_take) begin
            case (s2.op)
                gqtl_pkg::OP_START: begin
                    pen_x_next = cfg.root_x;
                    pen_y_next = cfg.root_y;
                end
                gqtl_pkg::OP_NEWLINE: begin
                    pen_x_next = cfg.root_x;
                    pen_y_next = gqtl_pkg::sat32(sum_y_line);
                end
                gqtl_pkg::OP_SPACE, gqtl_pkg::OP_TAB, gqtl_pkg::OP_GLYPH: begin
                    pen_x_next = gqtl_pkg::sat32(sum_x_step);
                end
                default: begin
                    pen_x_next = pen_x_reg;
                end
            endcase
        end
    end

    // Quad built from the pen position before the advance.
    always_comb begin
        quad_next.quad_x      = gqtl_pkg::sat32(sum_qx);
        quad_next.quad_y      = gqtl_pkg::sat32(sum_qy);
        quad_next.quad_width  = {4'd0, s2.size_w};
        quad_next.quad_height = {4'd0, s2.size_h};
        quad_next.uv_left     = s2.tex_left;
        quad_next.uv_top      = s2.tex_top;
        quad_next.uv_right    = s2.tex_right;
        quad_next.uv_bottom   = s2.tex_bottom;
        quad_next.quad_page   = s2.page_id;
        quad_next.quad_char   = s2.code;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pen_x_reg   <= pen_x_next;
            pen_y_reg   <= pen_y_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            quad_reg <= quad_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign quad    = quad_reg;

endmodule
